@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files, included by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, including while reset is high.
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("assertion failed");

// Checked only outside reset.
`define ASSERT_RUN(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

@@ rtl/utf8d_pkg.sv @@
`default_nettype none
package utf8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int MAX_RESULTS = 4;
   localparam int IDX_W  = 2;
   localparam int CNT_W  = 3;

   // lead byte payload masks
   localparam logic [7:0] MASK_LEAD2 = 8'h1f;
   localparam logic [7:0] MASK_LEAD3 = 8'h0f;
   localparam logic [7:0] MASK_LEAD4 = 8'h07;
   localparam logic [7:0] MASK_CONT  = 8'h3f;
   localparam logic [7:0] ASCII_TOP  = 8'h7f;

   // all results caused by one input byte
   typedef struct packed {
      logic [CNT_W-1:0]                  count;
      logic [MAX_RESULTS-1:0]            inv;
      logic [MAX_RESULTS-1:0][CP_W-1:0]  cp;
   } burst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

@@ rtl/utf8d_byte_if.sv @@
`default_nettype none
interface utf8d_byte_if;
   import utf8d_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

@@ rtl/utf8d_cp_if.sv @@
`default_nettype none
interface utf8d_cp_if;
   import utf8d_pkg::*;
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            invalid;
   logic            last;

   modport source (output valid, output code_point, output invalid, output last,
                   input ready);
   modport sink   (input valid, input code_point, input invalid, input last,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/utf8d_front.sv @@
`default_nettype none
module utf8d_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   utf8d_byte_if.sink                req_bus,
   input  wire utf8d_pkg::queue_status_type q_stat,
   output logic                      push,
   output utf8d_pkg::burst_type      burst
);
   import utf8d_pkg::*;

   // sequence state
   logic [7:0]      lead_ff, lead_in;
   logic [1:0]      need_ff, need_in;
   logic [1:0]      pend_cnt_ff, pend_cnt_in;
   logic [CP_W-1:0] acc_ff, acc_in;
   logic [7:0]      pend_ff [2];
   logic [7:0]      pend_in [2];

   logic            accept;
   logic            cont;
   logic [7:0]      b;
   logic [CP_W-1:0] acc_sum;
   logic [CNT_W-1:0] n;

   assign req_bus.ready = !q_stat.full;
   assign accept = req_bus.valid && !q_stat.full;
   assign b      = req_bus.byte_in;
   assign cont   = (b[7:6] == 2'b10);
   assign acc_sum = {acc_ff[CP_W-7:0], b[5:0]};

   // classify the byte and build its result burst
   always_comb begin
      lead_in     = lead_ff;
      need_in     = need_ff;
      pend_cnt_in = pend_cnt_ff;
      acc_in      = acc_ff;
      pend_in     = pend_ff;
      burst       = '0;
      n           = '0;
      if (need_ff != 2'd0 && cont) begin
         acc_in  = acc_sum;
         need_in = need_ff - 2'd1;
         if (need_ff == 2'd1) begin
            burst.cp[0] = acc_sum;
            n           = 3'd1;
            pend_cnt_in = 2'd0;
         end else if (pend_cnt_ff < 2'd2) begin
            pend_in[pend_cnt_ff[0]] = b;
            pend_cnt_in = pend_cnt_ff + 2'd1;
         end
      end else begin
         // broken sequence: flush lead and buffered bytes as raw
         if (need_ff != 2'd0) begin
            burst.cp[0]  = CP_W'(lead_ff);
            burst.cp[1]  = CP_W'(pend_ff[0]);
            burst.cp[2]  = CP_W'(pend_ff[1]);
            burst.inv[2:0] = 3'b111;
            n            = 3'd1 + {1'b0, pend_cnt_ff};
            need_in      = 2'd0;
            pend_cnt_in  = 2'd0;
         end
         // fresh handling of the new byte
         if (b <= ASCII_TOP) begin
            burst.cp[n[IDX_W-1:0]]  = CP_W'(b);
            burst.inv[n[IDX_W-1:0]] = 1'b0;
            n = n + 3'd1;
         end else if (b inside {[8'hc0:8'hf4]}) begin
            lead_in     = b;
            pend_cnt_in = 2'd0;
            if (b inside {[8'hc0:8'hdf]}) begin
               need_in = 2'd1;
               acc_in  = CP_W'(b & MASK_LEAD2);
            end else if (b inside {[8'he0:8'hef]}) begin
               need_in = 2'd2;
               acc_in  = CP_W'(b & MASK_LEAD3);
            end else begin
               need_in = 2'd3;
               acc_in  = CP_W'(b & MASK_LEAD4);
            end
         end else begin
            burst.cp[n[IDX_W-1:0]]  = CP_W'(b);
            burst.inv[n[IDX_W-1:0]] = 1'b1;
            n = n + 3'd1;
         end
      end
      burst.count = n;
   end

   assign push = accept && (n != '0);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff     <= 2'd0;
         pend_cnt_ff <= 2'd0;
      end else if (accept) begin
         need_ff     <= need_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff <= lead_in;
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/utf8d_queue.sv @@
`default_nettype none
module utf8d_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire utf8d_pkg::burst_type      wr_data,
   input  wire logic                      pop,
   output utf8d_pkg::burst_type           rd_data,
   output utf8d_pkg::queue_status_type    stat,
   output logic [$clog2(DEPTH+1)-1:0]     level
);
   import utf8d_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   burst_type        mem [DEPTH];
   burst_type        rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign stat.full  = (level_ff == LVL_W'(DEPTH));
   assign stat.empty = (level_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;
   assign rd_data = rd_data_ff;
   assign level   = level_ff;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   // head entry read ahead at the next read address, same-slot write passed through
   always_ff @(posedge clock) begin
      if (do_push && (wr_ptr_ff == rd_ptr_in)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_ptr_in];
      end
   end

endmodule
`default_nettype wire

@@ rtl/utf8d_back.sv @@
`default_nettype none
module utf8d_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire utf8d_pkg::burst_type      head,
   input  wire utf8d_pkg::queue_status_type q_stat,
   output logic                           pop,
   utf8d_cp_if.source                     rsp_bus
);
   import utf8d_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [CP_W-1:0]  cp_ff;
   logic             inv_ff, last_ff;
   logic             load, take, last_entry;

   assign load       = !valid_ff || rsp_bus.ready;
   assign take       = load && !q_stat.empty;
   assign last_entry = ({1'b0, idx_ff} == head.count - 3'd1);
   assign pop        = take && last_entry;

   // walk through the entries of the head burst
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = !q_stat.empty;
      end
      if (take) begin
         idx_in = last_entry ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (take) begin
         cp_ff   <= head.cp[idx_ff];
         inv_ff  <= head.inv[idx_ff];
         last_ff <= last_entry;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.code_point = cp_ff;
   assign rsp_bus.invalid    = inv_ff;
   assign rsp_bus.last       = last_ff;

endmodule
`default_nettype wire

@@ rtl/utf8_byte_stream_decoder.sv @@
// Channel   Dir  Handshake     Item
// req_bus   in   valid/ready   byte_in: one raw byte of the stream
// rsp_bus   out  valid/ready   code_point, invalid, last: one result
//
// One byte is accepted per cycle while the burst queue has room.
// A byte's results (0 to 4) leave one per cycle from the output register
// while rsp_bus is ready, so the output side sets the sustained rate.
// A result is registered in the queue's head register, then in the output register.
// Synchronous reset closes any open sequence and empties queue and output.
// A stalled output fills the queue of QUEUE_DEPTH bursts before req_bus.ready drops.
`default_nettype none
module utf8_byte_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   utf8d_byte_if.sink  req_bus,
   utf8d_cp_if.source  rsp_bus
);
   import utf8d_pkg::*;
   `include "assert_macros.svh"

   burst_type        burst, head;
   queue_status_type q_stat;
   logic             push, pop;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

   utf8d_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_stat  (q_stat),
      .push    (push),
      .burst   (burst)
   );

   utf8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (burst),
      .pop     (pop),
      .rd_data (head),
      .stat    (q_stat),
      .level   (q_level)
   );

   utf8d_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // checks
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_bus.valid)
   `ASSERT_RUN(a_valid_is_last, clock, reset,
      (rsp_bus.valid && !rsp_bus.invalid) |-> rsp_bus.last)
   `ASSERT_RUN(a_level_bound, clock, reset,
      q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
   `ASSERT_RUN(a_no_burst_when_full, clock, reset,
      q_stat.full |-> !(req_bus.ready || push))

endmodule
`default_nettype wire
